// ----- hdl/fptw_pkg.sv -----
`timescale 1ns / 1ps

package fptw_pkg;

   localparam int CMD_W    = 2;
   localparam int VA_W     = 48;
   localparam int FRAME_W  = 40;
   localparam int PA_W     = 52;
   localparam int ENTRY_W  = 42;
   localparam int IDX_W    = 9;
   localparam int OFFSET_W = 12;
   localparam int ENTRIES  = 512;
   localparam int ROOT_W   = 4;
   localparam int LEVEL_W  = 2;

   localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MAP       = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNMAP     = 2'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_TOP  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic mem_read;
      logic follow;
      logic wr_table;
      logic wr_leaf;
      logic wr_unmap;
      logic take_leaf;
      logic set_fail;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [LEVEL_W-1:0] level;
      logic               root_ok;
      logic               entry_follows;
      logic               entry_present;
      logic               free_ok;
      logic               clear_last;
   } dp_sts_type;

endpackage

// ----- hdl/fptw_dp.sv -----
`timescale 1ns / 1ps

module fptw_dp #(
   parameter int TABLE_PAGES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fptw_pkg::ROOT_W-1:0]     csr_wr_data,
   input  logic [fptw_pkg::CMD_W-1:0]      req_cmd,
   input  logic [fptw_pkg::VA_W-1:0]       req_virt_addr,
   input  logic [fptw_pkg::FRAME_W-1:0]    req_phys_frame,
   input  logic                            req_user_page,
   input  fptw_pkg::dp_cmd_type            dp_cmd,
   output fptw_pkg::dp_sts_type            dp_sts,
   output logic [fptw_pkg::PA_W-1:0]       rsp_phys_addr,
   output logic                            rsp_is_present,
   output logic                            rsp_status
);

   localparam int PW    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int AW    = PW + fptw_pkg::IDX_W;
   localparam int DEPTH = TABLE_PAGES * fptw_pkg::ENTRIES;

   localparam logic [PW:0]                    PAGE_LIMIT  = (PW+1)'(TABLE_PAGES);
   localparam logic [fptw_pkg::FRAME_W-1:0]   FRAME_LIMIT = fptw_pkg::FRAME_W'(TABLE_PAGES);
   localparam logic [31:0]                    ROOT_LIMIT  = 32'(TABLE_PAGES);
   localparam logic [AW-1:0]                  LAST_SLOT   = AW'(DEPTH - 1);

   logic [fptw_pkg::ENTRY_W-1:0] store_mem [DEPTH];

   logic [fptw_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [PW:0]                  next_free_ff, next_free_in;
   logic [AW-1:0]                clear_cnt_ff, clear_cnt_in;
   logic [fptw_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [fptw_pkg::VA_W-1:0]    va_ff, va_in;
   logic [fptw_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic                         user_ff, user_in;
   logic [fptw_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [PW-1:0]                page_ff, page_in;
   logic [fptw_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [fptw_pkg::PA_W-1:0]    res_phys_ff, res_phys_in;
   logic                         res_present_ff, res_present_in;
   logic                         res_fail_ff, res_fail_in;
   logic [fptw_pkg::PA_W-1:0]    rsp_phys_ff, rsp_phys_in;
   logic                         rsp_present_ff, rsp_present_in;
   logic                         rsp_fail_ff, rsp_fail_in;

   logic [fptw_pkg::IDX_W-1:0]   idx;
   logic [AW-1:0]                slot;
   logic [AW-1:0]                wr_addr;
   logic [fptw_pkg::ENTRY_W-1:0] wr_data;
   logic                         mem_we;
   logic [fptw_pkg::FRAME_W-1:0] entry_frame;

   always_comb begin
      unique case (level_ff)
         2'd0: idx = va_ff[47:39];
         2'd1: idx = va_ff[38:30];
         2'd2: idx = va_ff[29:21];
         2'd3: idx = va_ff[20:12];
         default: idx = va_ff[20:12];
      endcase
   end

   assign slot        = {page_ff, idx};
   assign entry_frame = rd_data_ff[fptw_pkg::ENTRY_W-1:2];
   assign mem_we      = dp_cmd.clear_step | dp_cmd.wr_table | dp_cmd.wr_leaf | dp_cmd.wr_unmap;
   assign wr_addr     = dp_cmd.clear_step ? clear_cnt_ff : slot;

   always_comb begin
      priority if (dp_cmd.wr_table) begin
         wr_data = {fptw_pkg::FRAME_W'(next_free_ff[PW-1:0]), 1'b1, 1'b1};
      end else if (dp_cmd.wr_leaf) begin
         wr_data = {frame_ff, user_ff, 1'b1};
      end else begin
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (dp_cmd.mem_read) begin
         rd_data_ff <= store_mem[slot];
      end
   end

   always_comb begin
      root_in        = csr_wr_en ? csr_wr_data : root_ff;
      clear_cnt_in   = dp_cmd.clear_step ? clear_cnt_ff + 1'b1 : clear_cnt_ff;
      next_free_in   = next_free_ff;
      cmd_in         = cmd_ff;
      va_in          = va_ff;
      frame_in       = frame_ff;
      user_in        = user_ff;
      level_in       = level_ff;
      page_in        = page_ff;
      res_phys_in    = res_phys_ff;
      res_present_in = res_present_ff;
      res_fail_in    = res_fail_ff;
      rsp_phys_in    = rsp_phys_ff;
      rsp_present_in = rsp_present_ff;
      rsp_fail_in    = rsp_fail_ff;

      if (dp_cmd.load_item) begin
         cmd_in         = req_cmd;
         va_in          = req_virt_addr;
         frame_in       = req_phys_frame;
         user_in        = req_user_page;
         level_in       = fptw_pkg::LEVEL_TOP;
         page_in        = PW'(root_ff);
         res_phys_in    = '0;
         res_present_in = 1'b0;
         res_fail_in    = 1'b0;
      end
      if (dp_cmd.follow) begin
         page_in  = PW'(entry_frame);
         level_in = level_ff + 1'b1;
      end
      if (dp_cmd.wr_table) begin
         page_in      = next_free_ff[PW-1:0];
         level_in     = level_ff + 1'b1;
         next_free_in = next_free_ff + 1'b1;
      end
      if (dp_cmd.take_leaf) begin
         res_phys_in    = {entry_frame, va_ff[fptw_pkg::OFFSET_W-1:0]};
         res_present_in = 1'b1;
      end
      if (dp_cmd.set_fail) begin
         res_fail_in = 1'b1;
      end
      if (dp_cmd.out_load) begin
         rsp_phys_in    = res_phys_ff;
         rsp_present_in = res_present_ff;
         rsp_fail_in    = res_fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         next_free_ff <= (PW+1)'(1);
         clear_cnt_ff <= '0;
      end else begin
         root_ff      <= root_in;
         next_free_ff <= next_free_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      va_ff          <= va_in;
      frame_ff       <= frame_in;
      user_ff        <= user_in;
      level_ff       <= level_in;
      page_ff        <= page_in;
      res_phys_ff    <= res_phys_in;
      res_present_ff <= res_present_in;
      res_fail_ff    <= res_fail_in;
      rsp_phys_ff    <= rsp_phys_in;
      rsp_present_ff <= rsp_present_in;
      rsp_fail_ff    <= rsp_fail_in;
   end

   always_comb begin
      dp_sts.cmd           = cmd_ff;
      dp_sts.level         = level_ff;
      dp_sts.root_ok       = 32'(root_ff) < ROOT_LIMIT;
      dp_sts.entry_follows = rd_data_ff[0] && (entry_frame < FRAME_LIMIT);
      dp_sts.entry_present = rd_data_ff[0];
      dp_sts.free_ok       = next_free_ff < PAGE_LIMIT;
      dp_sts.clear_last    = clear_cnt_ff == LAST_SLOT;
   end

   assign rsp_phys_addr  = rsp_phys_ff;
   assign rsp_is_present = rsp_present_ff;
   assign rsp_status     = rsp_fail_ff;

endmodule

// ----- hdl/fptw_ctrl.sv -----
`timescale 1ns / 1ps

module fptw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  fptw_pkg::dp_sts_type dp_sts,
   output fptw_pkg::dp_cmd_type dp_cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       is_map;
   logic       is_unmap;
   logic       at_leaf;

   assign is_map   = dp_sts.cmd == fptw_pkg::CMD_MAP;
   assign is_unmap = dp_sts.cmd == fptw_pkg::CMD_UNMAP;
   assign at_leaf  = dp_sts.level == fptw_pkg::LEVEL_LEAF;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         S_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (dp_sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load_item = 1'b1;
               state_in         = S_READ;
            end
         end
         S_READ: begin
            priority if (!dp_sts.root_ok) begin
               dp_cmd.set_fail = is_map;
               state_in        = S_DONE;
            end else if (at_leaf && is_map) begin
               dp_cmd.wr_leaf = 1'b1;
               state_in       = S_DONE;
            end else if (at_leaf && is_unmap) begin
               dp_cmd.wr_unmap = 1'b1;
               state_in        = S_DONE;
            end else begin
               dp_cmd.mem_read = 1'b1;
               state_in        = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (at_leaf) begin
               dp_cmd.take_leaf = dp_sts.entry_present;
               state_in         = S_DONE;
            end else if (dp_sts.entry_follows) begin
               dp_cmd.follow = 1'b1;
               state_in      = S_READ;
            end else if (is_map && dp_sts.free_ok) begin
               dp_cmd.wr_table = 1'b1;
               state_in        = S_READ;
            end else begin
               dp_cmd.set_fail = is_map;
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.out_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/four_level_page_table_engine.sv -----
// Four-level page table engine: keeps x86-64 style page tables in an on-chip
// store of TABLE_PAGES pages of 512 entries and serves one operation per beat.
// Request beat (req_): cmd translate, present query, map page or unmap page,
// with a 48-bit virtual address, a frame number and a user flag. Response beat
// (rsp_): physical address, present flag and map status; one per request.
// csr_ writes the root table page; write it only while the engine is idle.
// A full walk reads the store once per level: it issues the read, then evaluates
// the registered read data; map and unmap write the leaf in place of its read.
// One request is in flight at a time; the next is accepted the cycle after
// the response is loaded.
// Reset clears the control state, then sweeps the store clean, one entry a
// cycle; req_stall stays high during the sweep.
// A stalled response holds in the output register; the engine finishes its
// current walk and waits there until the response is taken.
`timescale 1ns / 1ps

module four_level_page_table_engine #(
   parameter int TABLE_PAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [47:0] req_virt_addr,
   input  logic [39:0] req_phys_frame,
   input  logic        req_user_page,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [51:0] rsp_phys_addr,
   output logic        rsp_is_present,
   output logic        rsp_status
);

   fptw_pkg::dp_cmd_type dp_cmd;
   fptw_pkg::dp_sts_type dp_sts;

   fptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_sts    (dp_sts),
      .dp_cmd    (dp_cmd)
   );

   fptw_dp #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_cmd        (req_cmd),
      .req_virt_addr  (req_virt_addr),
      .req_phys_frame (req_phys_frame),
      .req_user_page  (req_user_page),
      .dp_cmd         (dp_cmd),
      .dp_sts         (dp_sts),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_is_present (rsp_is_present),
      .rsp_status     (rsp_status)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted during a walk");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({dp_cmd.clear_step, dp_cmd.wr_table, dp_cmd.wr_leaf, dp_cmd.wr_unmap}))
      else $error("more than one write to the table store in a cycle");

   a_sweep_stalls: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_step |-> req_stall)
      else $error("request port open during the clearing sweep");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("response register reloaded while its beat is stalled");

endmodule
